// ===== hdl/longest_prefix_route_lookup_assert.svh =====
// Assertion macros for the route lookup block.
// Each macro samples on clk and is disabled while rst is high.
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_ASSERT_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_ASSERT_SVH

// same-cycle implication
`define LPRL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("route lookup check failed");

// next-cycle implication
`define LPRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("route lookup check failed");

`endif

// ===== hdl/lprl_pkg.sv =====
// Shared types and constants of the route lookup block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package lprl_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int PORT_COUNT_DEF    = 16;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 4;
  localparam int PORT_W   = 4;
  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 6;
  localparam int WIDE_W   = 9;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_INVAL  = 2'd2
  } lprl_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } lprl_state_t;

  typedef struct packed {
    logic wr;
    logic inval;
    logic start;
    logic issue;
    logic rsp_load;
  } lprl_cmd_t;

  typedef struct packed {
    logic last;
    logic pipe_busy;
    logic rsp_free;
  } lprl_stat_t;

endpackage

// ===== hdl/lprl_if.sv =====
// Valid/ready channel interfaces for route requests and lookup results.
// Depends on lprl_pkg for field widths.
interface lprl_req_if;
  logic                           valid;
  logic                           ready;
  logic [lprl_pkg::OPCODE_W-1:0]  opcode;
  logic [lprl_pkg::INDEX_W-1:0]   entry_index;
  logic [lprl_pkg::ADDR_W-1:0]    entry_dest;
  logic [lprl_pkg::ADDR_W-1:0]    entry_mask;
  logic [lprl_pkg::ADDR_W-1:0]    entry_gateway;
  logic [lprl_pkg::PORT_W-1:0]    entry_port;
  logic [lprl_pkg::ADDR_W-1:0]    lookup_addr;

  modport source (
    output valid, opcode, entry_index, entry_dest, entry_mask, entry_gateway,
           entry_port, lookup_addr,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, entry_dest, entry_mask, entry_gateway,
           entry_port, lookup_addr,
    output ready
  );
endinterface

interface lprl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [lprl_pkg::PORT_W-1:0]   out_port;
  logic [lprl_pkg::ADDR_W-1:0]   next_hop;
  logic [lprl_pkg::LEN_W-1:0]    prefix_len;
  logic [lprl_pkg::INDEX_W-1:0]  match_index;

  modport source (
    output valid, hit, out_port, next_hop, prefix_len, match_index,
    input  ready
  );
  modport sink (
    input  valid, hit, out_port, next_hop, prefix_len, match_index,
    output ready
  );
endinterface

// ===== hdl/lprl_ctrl.sv =====
// Request controller: decodes opcodes, sequences the table scan and result load.
// Depends on lprl_pkg for state, opcode, command and status types.
module lprl_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [lprl_pkg::OPCODE_W-1:0] opcode,
  output logic                          req_ready,
  input  lprl_pkg::lprl_stat_t          stat,
  output lprl_pkg::lprl_cmd_t           cmd
);

  lprl_pkg::lprl_state_t state;
  lprl_pkg::lprl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lprl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      lprl_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (opcode)
            lprl_pkg::OP_WRITE: begin
              cmd.wr = 1'b1;
            end
            lprl_pkg::OP_INVAL: begin
              cmd.inval = 1'b1;
            end
            lprl_pkg::OP_LOOKUP: begin
              cmd.start  = 1'b1;
              state_next = lprl_pkg::ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      lprl_pkg::ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.last) begin
          state_next = lprl_pkg::ST_DRAIN;
        end
      end
      lprl_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy && stat.rsp_free) begin
          cmd.rsp_load = 1'b1;
          state_next   = lprl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lprl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/lprl_dp.sv =====
// Route table datapath: entry memories, valid bits, scan pipeline and result register.
// Depends on lprl_pkg and lprl_rsp_if; driven by commands from lprl_ctrl.
module lprl_dp #(
  parameter int TABLE_ENTRIES = lprl_pkg::TABLE_ENTRIES_DEF,
  parameter int PORT_COUNT    = lprl_pkg::PORT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lprl_pkg::lprl_cmd_t           cmd,
  output lprl_pkg::lprl_stat_t          stat,
  input  logic [lprl_pkg::INDEX_W-1:0]  entry_index,
  input  logic [lprl_pkg::ADDR_W-1:0]   entry_dest,
  input  logic [lprl_pkg::ADDR_W-1:0]   entry_mask,
  input  logic [lprl_pkg::ADDR_W-1:0]   entry_gateway,
  input  logic [lprl_pkg::PORT_W-1:0]   entry_port,
  input  logic [lprl_pkg::ADDR_W-1:0]   lookup_addr,
  lprl_rsp_if.source                    rsp
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ADDR_W = lprl_pkg::ADDR_W;
  localparam int PORT_W = lprl_pkg::PORT_W;
  localparam int LEN_W  = lprl_pkg::LEN_W;
  localparam int WIDE_W = lprl_pkg::WIDE_W;

  function automatic logic [3:0] lead_ones8(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int k = 7; k >= 0; k--) begin
      if (run && b[k]) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  function automatic logic [LEN_W-1:0] join_len(input logic [3:0] c3, input logic [3:0] c2,
                                                input logic [3:0] c1, input logic [3:0] c0);
    logic [LEN_W-1:0] n;
    n = LEN_W'(c3);
    if (c3 == 4'd8) begin
      n = n + LEN_W'(c2);
      if (c2 == 4'd8) begin
        n = n + LEN_W'(c1);
        if (c1 == 4'd8) begin
          n = n + LEN_W'(c0);
        end
      end
    end
    return n;
  endfunction

  logic [ADDR_W-1:0] mem_dest [TABLE_ENTRIES];
  logic [ADDR_W-1:0] mem_mask [TABLE_ENTRIES];
  logic [ADDR_W-1:0] mem_gw   [TABLE_ENTRIES];
  logic [PORT_W-1:0] mem_port [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  logic [WIDE_W-1:0] idx_wide;
  logic [IDX_W-1:0]  wr_addr;
  logic              idx_ok;
  logic              port_ok;
  logic              do_write;

  logic [IDX_W-1:0]  cnt;
  logic [ADDR_W-1:0] addr_q;

  logic              p1;
  logic              rd_live;
  logic [ADDR_W-1:0] rd_dest;
  logic [ADDR_W-1:0] rd_mask;
  logic [ADDR_W-1:0] rd_gw;
  logic [PORT_W-1:0] rd_port;
  logic [IDX_W-1:0]  rd_idx;

  logic              p2;
  logic              a_live;
  logic [3:0]        a_cnt [4];
  logic [ADDR_W-1:0] a_gw;
  logic [PORT_W-1:0] a_port;
  logic [IDX_W-1:0]  a_idx;

  logic [LEN_W-1:0]  a_len;
  logic              upd;

  logic              best_found;
  logic [LEN_W-1:0]  best_len;
  logic [ADDR_W-1:0] best_gw;
  logic [PORT_W-1:0] best_port;
  logic [IDX_W-1:0]  best_idx;
  logic [WIDE_W-1:0] best_idx_wide;

  logic                         rsp_valid_q;
  logic                         rsp_hit_q;
  logic [PORT_W-1:0]            rsp_port_q;
  logic [ADDR_W-1:0]            rsp_hop_q;
  logic [LEN_W-1:0]             rsp_len_q;
  logic [lprl_pkg::INDEX_W-1:0] rsp_idx_q;

  assign idx_wide = WIDE_W'(entry_index);
  assign wr_addr  = idx_wide[IDX_W-1:0];
  assign idx_ok   = idx_wide < WIDE_W'(TABLE_ENTRIES);
  assign port_ok  = WIDE_W'(entry_port) < WIDE_W'(PORT_COUNT);
  assign do_write = cmd.wr && idx_ok && port_ok;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem_dest[wr_addr] <= entry_dest;
      mem_mask[wr_addr] <= entry_mask;
      mem_gw[wr_addr]   <= entry_gateway;
      mem_port[wr_addr] <= entry_port;
    end
    if (cmd.issue) begin
      rd_dest <= mem_dest[cnt];
      rd_mask <= mem_mask[cnt];
      rd_gw   <= mem_gw[cnt];
      rd_port <= mem_port[cnt];
      rd_idx  <= cnt;
      rd_live <= valid[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (do_write) begin
      valid[wr_addr] <= 1'b1;
    end else if (cmd.inval && idx_ok) begin
      valid[wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      p1  <= 1'b0;
      p2  <= 1'b0;
    end else begin
      p1 <= cmd.issue;
      p2 <= p1;
      if (cmd.start) begin
        cnt <= '0;
      end else if (cmd.issue) begin
        cnt <= cnt + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr_q <= lookup_addr;
    end
    a_live <= p1 && rd_live && (((addr_q ^ rd_dest) & rd_mask) == '0);
    a_cnt[3] <= lead_ones8(rd_mask[31:24]);
    a_cnt[2] <= lead_ones8(rd_mask[23:16]);
    a_cnt[1] <= lead_ones8(rd_mask[15:8]);
    a_cnt[0] <= lead_ones8(rd_mask[7:0]);
    a_gw     <= rd_gw;
    a_port   <= rd_port;
    a_idx    <= rd_idx;
  end

  assign a_len = join_len(a_cnt[3], a_cnt[2], a_cnt[1], a_cnt[0]);
  assign upd   = p2 && a_live && (!best_found || (a_len > best_len));

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else if (cmd.start) begin
      best_found <= 1'b0;
    end else if (upd) begin
      best_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_len  <= '0;
      best_gw   <= '0;
      best_port <= '0;
      best_idx  <= '0;
    end else if (upd) begin
      best_len  <= a_len;
      best_gw   <= a_gw;
      best_port <= a_port;
      best_idx  <= a_idx;
    end
  end

  assign best_idx_wide = WIDE_W'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      rsp_hit_q  <= best_found;
      rsp_port_q <= best_port;
      rsp_hop_q  <= best_gw;
      rsp_len_q  <= best_len;
      rsp_idx_q  <= best_idx_wide[lprl_pkg::INDEX_W-1:0];
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.hit         = rsp_hit_q;
  assign rsp.out_port    = rsp_port_q;
  assign rsp.next_hop    = rsp_hop_q;
  assign rsp.prefix_len  = rsp_len_q;
  assign rsp.match_index = rsp_idx_q;

  assign stat.last      = cnt == IDX_W'(TABLE_ENTRIES - 1);
  assign stat.pipe_busy = p1 || p2;
  assign stat.rsp_free  = !rsp_valid_q || rsp.ready;

endmodule

// ===== hdl/longest_prefix_route_lookup.sv =====
// Longest-prefix IPv4 route lookup over a TABLE_ENTRIES-slot table.
// Write and invalidate are done in the idle state; the block stays ready for the next request.
// A lookup reads one slot per cycle through a single compare unit; the result register is loaded once the
// scan pipeline has drained and the previous result was taken, and no new request is accepted until then.
// Synchronous rst clears the valid bits, the controller, the scan pipeline flags and the result valid flag.
`include "longest_prefix_route_lookup_assert.svh"

module longest_prefix_route_lookup #(
  parameter int TABLE_ENTRIES = lprl_pkg::TABLE_ENTRIES_DEF,
  parameter int PORT_COUNT    = lprl_pkg::PORT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  lprl_req_if.sink    req,
  lprl_rsp_if.source  rsp
);

  lprl_pkg::lprl_cmd_t  cmd;
  lprl_pkg::lprl_stat_t stat;

  lprl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .opcode    (req.opcode),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lprl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PORT_COUNT    (PORT_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .entry_index   (req.entry_index),
    .entry_dest    (req.entry_dest),
    .entry_mask    (req.entry_mask),
    .entry_gateway (req.entry_gateway),
    .entry_port    (req.entry_port),
    .lookup_addr   (req.lookup_addr),
    .rsp           (rsp)
  );

  `LPRL_ASSERT_NEXT(a_lookup_blocks, req.valid && req.ready && req.opcode == lprl_pkg::OP_LOOKUP, !req.ready)
  `LPRL_ASSERT_NOW(a_no_overwrite, cmd.rsp_load, !rsp.valid || rsp.ready)
  `LPRL_ASSERT_NEXT(a_load_shows, cmd.rsp_load, rsp.valid)
  `LPRL_ASSERT_NOW(a_miss_zero, rsp.valid && !rsp.hit, rsp.prefix_len == '0 && rsp.out_port == '0 && rsp.next_hop == '0 && rsp.match_index == '0)

endmodule
